// File: rtl/swstat_pkg.sv
`default_nettype none

package swstat_pkg;

  localparam int DATA_W    = 32;
  localparam int LEN_W     = 7;
  localparam int OUT_W     = 3 * DATA_W;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(10);

  typedef logic signed [DATA_W-1:0] sample_t;

endpackage

`default_nettype wire

// File: rtl/swstat_ring.sv
`default_nettype none

module swstat_ring #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6
) (
  input  wire                         clk,
  input  wire                         wr_en,
  input  wire  [ADDR_W-1:0]           wr_addr,
  input  wire  [swstat_pkg::DATA_W-1:0] wr_data,
  input  wire                         rd_en,
  input  wire  [ADDR_W-1:0]           rd_addr,
  output logic [swstat_pkg::DATA_W-1:0] rd_data
);

  import swstat_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/swstat_div.sv
`default_nettype none

module swstat_div #(
  parameter int SUM_W = 38,
  parameter int DIV_W = 7
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  input  wire  signed [SUM_W-1:0]      dividend,
  input  wire         [DIV_W-1:0]      divisor,
  output logic                         done,
  output logic [swstat_pkg::DATA_W-1:0] quotient
);

  import swstat_pkg::*;

  localparam int CNT_W = $clog2(SUM_W + 1);

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic                neg_r, neg_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [SUM_W-1:0]    mag_r, mag_nxt;
  logic [DIV_W-1:0]    rem_r, rem_nxt;
  logic [DIV_W-1:0]    dsr_r, dsr_nxt;
  logic [DIV_W:0]      rem_sh;
  logic [DIV_W:0]      rem_sub;
  logic                ge;
  logic [SUM_W-1:0]    dvd_u;
  logic [SUM_W-1:0]    quo_full;

  // restoring divide, one quotient bit per cycle
  always_comb begin
    dvd_u    = $unsigned(dividend);
    rem_sh   = {rem_r, mag_r[SUM_W-1]};
    ge       = rem_sh >= {1'b0, dsr_r};
    rem_sub  = rem_sh - {1'b0, dsr_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    mag_nxt  = mag_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      neg_nxt  = dividend[SUM_W-1];
      mag_nxt  = dividend[SUM_W-1] ? (~dvd_u + 1'b1) : dvd_u;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
      cnt_nxt  = CNT_W'(SUM_W);
    end else if (busy_r) begin
      rem_nxt = ge ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
      mag_nxt = {mag_r[SUM_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    neg_r <= neg_nxt;
    cnt_r <= cnt_nxt;
    mag_r <= mag_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign quo_full = neg_r ? (~mag_r + 1'b1) : mag_r;
  assign quotient = quo_full[DATA_W-1:0];
  assign done     = done_r;

endmodule

`default_nettype wire

// File: rtl/sliding_window_statistics.sv
`default_nettype none

// channel   dir  handshake            payload
// in_       in   in_tvalid/in_tready  tdata: sample
// out_      out  out_tvalid/out_tready tdata: avg, min, max; tuser: window_complete
// cfg_      in   cfg_wr_en            cfg_wr_data: window_len
//
// each accepted sample is processed with one ring read per entry, n the window length,
// then one quotient bit per cycle in the serial divider
// ring clearing is free: a fill count marks unwritten entries as zero
// synchronous active-low reset; in_tready stays low until the result is registered
// and while cfg_wr_en is high
// a pending result stalls only the final output load

module sliding_window_statistics #(
  parameter int MAX_WINDOW = 64
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_tvalid,
  output logic                             in_tready,
  input  wire  [swstat_pkg::DATA_W-1:0]    in_tdata,   // sample
  output logic                             out_tvalid,
  input  wire                              out_tready,
  output logic [swstat_pkg::OUT_W-1:0]     out_tdata,  // window_avg, window_min, window_max
  output logic                             out_tuser,  // window_complete
  input  wire                              cfg_wr_en,
  input  wire  [swstat_pkg::LEN_W-1:0]     cfg_wr_data // window_len
);

  import swstat_pkg::*;

  localparam int IW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CW    = $clog2(MAX_WINDOW + 1);
  localparam int LW    = (CW > LEN_W) ? CW : LEN_W;
  localparam int SUM_W = DATA_W + IW;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DIV,
    S_OUT
  } state_t;

  state_t             state_r, state_nxt;
  logic [LEN_W-1:0]   wlen_r, wlen_nxt;
  logic [IW-1:0]      widx_r, widx_nxt;
  logic [CW-1:0]      fill_r, fill_nxt;
  logic [CW-1:0]      ridx_r, ridx_nxt;
  logic               rvld_r, rvld_nxt;
  logic               rlive_r, rlive_nxt;
  logic               first_r, first_nxt;
  logic               cmpl_r, cmpl_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  sample_t            lo_r, lo_nxt;
  sample_t            hi_r, hi_nxt;
  logic               ovld_r, ovld_nxt;
  logic [OUT_W-1:0]   odata_r, odata_nxt;
  logic               ouser_r, ouser_nxt;

  logic [LW-1:0]      wl_ext;
  logic [LW-1:0]      n_ext;
  logic [CW-1:0]      n;
  logic [IW-1:0]      pos;
  logic [CW-1:0]      pos_inc;
  logic [IW-1:0]      pos_next;
  logic               accept;
  logic               rd_en;
  logic [DATA_W-1:0]  rd_data;
  sample_t            v;
  logic               div_start;
  logic               div_done;
  logic [DATA_W-1:0]  quotient;

  // effective window length, clamped to 1 .. MAX_WINDOW
  always_comb begin
    wl_ext = LW'(wlen_r);
    if (wl_ext == '0) begin
      n_ext = LW'(1);
    end else if (wl_ext > LW'(MAX_WINDOW)) begin
      n_ext = LW'(MAX_WINDOW);
    end else begin
      n_ext = wl_ext;
    end
    n = n_ext[CW-1:0];
  end

  always_comb begin
    pos      = (CW'(widx_r) >= n) ? '0 : widx_r;
    pos_inc  = CW'(pos) + 1'b1;
    pos_next = (pos_inc >= n) ? '0 : pos_inc[IW-1:0];
  end

  assign accept = in_tvalid && in_tready;
  assign rd_en  = (state_r == S_SCAN) && (ridx_r < n);
  assign v      = rlive_r ? sample_t'(rd_data) : '0;

  swstat_ring #(
    .DEPTH  (MAX_WINDOW),
    .ADDR_W (IW)
  ) u_ring (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (pos),
    .wr_data (in_tdata),
    .rd_en   (rd_en),
    .rd_addr (ridx_r[IW-1:0]),
    .rd_data (rd_data)
  );

  swstat_div #(
    .SUM_W (SUM_W),
    .DIV_W (CW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  (n),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    state_nxt = state_r;
    wlen_nxt  = wlen_r;
    widx_nxt  = widx_r;
    fill_nxt  = fill_r;
    ridx_nxt  = ridx_r;
    rvld_nxt  = 1'b0;
    rlive_nxt = rlive_r;
    first_nxt = first_r;
    cmpl_nxt  = cmpl_r;
    sum_nxt   = sum_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    ovld_nxt  = ovld_r;
    odata_nxt = odata_r;
    ouser_nxt = ouser_r;
    div_start = 1'b0;

    if (ovld_r && out_tready) begin
      ovld_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (cfg_wr_en) begin
          wlen_nxt = cfg_wr_data;
          widx_nxt = '0;
          fill_nxt = '0;
        end else if (accept) begin
          widx_nxt  = pos_next;
          cmpl_nxt  = (pos_next == '0);
          if (CW'(pos) == fill_r) begin
            fill_nxt = fill_r + 1'b1;
          end
          ridx_nxt  = '0;
          first_nxt = 1'b1;
          sum_nxt   = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (rd_en) begin
          ridx_nxt  = ridx_r + 1'b1;
          rvld_nxt  = 1'b1;
          rlive_nxt = ridx_r < fill_r;
        end
        if (rvld_r) begin
          sum_nxt   = sum_r + SUM_W'(v);
          first_nxt = 1'b0;
          if (first_r || v < lo_r) begin
            lo_nxt = v;
          end
          if (first_r || v > hi_r) begin
            hi_nxt = v;
          end
        end else if (!rd_en) begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!ovld_r || out_tready) begin
          ovld_nxt  = 1'b1;
          odata_nxt = {hi_r, lo_r, quotient};
          ouser_nxt = cmpl_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      wlen_r  <= LEN_RESET;
      widx_r  <= '0;
      fill_r  <= '0;
      rvld_r  <= 1'b0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wlen_r  <= wlen_nxt;
      widx_r  <= widx_nxt;
      fill_r  <= fill_nxt;
      rvld_r  <= rvld_nxt;
      ovld_r  <= ovld_nxt;
    end
    ridx_r  <= ridx_nxt;
    rlive_r <= rlive_nxt;
    first_r <= first_nxt;
    cmpl_r  <= cmpl_nxt;
    sum_r   <= sum_nxt;
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    odata_r <= odata_nxt;
    ouser_r <= ouser_nxt;
  end

  assign in_tready  = (state_r == S_IDLE) && !cfg_wr_en;
  assign out_tvalid = ovld_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = ouser_r;

endmodule

`default_nettype wire
